@@ rtl/core/histogram_auto_exposure_defines.svh @@
// Assertion macros for the auto exposure block
`ifndef HISTOGRAM_AUTO_EXPOSURE_DEFINES_SVH
`define HISTOGRAM_AUTO_EXPOSURE_DEFINES_SVH

// Implication check on the rising clock edge, held off during reset
`define HAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check on the rising clock edge
`define HAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hae_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hae_pkg;
    localparam int BUCKETS = 64;
    localparam int BIDX_W = $clog2(BUCKETS);
    localparam int BCNT_W = BIDX_W + 1;
    localparam int TOT_W = 30;
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
    localparam logic [10:0] RATIO_CAP = 11'd1792;
    localparam int QDEPTH = 2;

    localparam logic [2:0] REG_PCT = 3'd0;
    localparam logic [2:0] REG_TGT = 3'd1;
    localparam logic [2:0] REG_MAXG = 3'd2;
    localparam logic [2:0] REG_KNEE = 3'd3;
    localparam logic [2:0] REG_MAXE = 3'd4;

    // Job handed from the front part to the back part at end of frame
    typedef struct packed {
        logic        valid;
        logic [BCNT_W-1:0] n;
        logic [TOT_W-1:0]  total;
        logic [19:0] fe;
        logic [15:0] fg;
        logic [19:0] pe;
        logic [15:0] pg;
    } t_job;

    typedef struct packed {
        logic [10:0] pct;
        logic [10:0] tgt;
        logic [15:0] maxg;
        logic [19:0] knee;
        logic [19:0] maxe;
    } t_cfg;
endpackage
`default_nettype wire

@@ rtl/core/histogram_auto_exposure.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Histogram percentile auto exposure.
// Input channel: push/full. Push one histogram bucket per transfer; the bucket
// marked is_last carries hist_valid, frame and prior exposure/gain and
// closes the frame.
// Result channel: empty/pop. One result (new exposure, new gain) per frame,
// held on the ports while empty is low, removed by pop.
// Config channel: valid/ready with index and data; ready is always high.
// Throughput: one bucket per cycle while a frame is streaming and full is low.
// After the last bucket, the job passes through a scan of the bins over the bin
// memory read port, up to four passes of the shared bit-serial divider and the
// control states.
// Full rises after a last bucket and stays high until the result has been
// computed and is in the output register.
// Reset clears the counters, job count, state and config registers to defaults,
// not the queue entries, datapath registers or bin memory. A stalled receiver
// holds the result and the block parks the next computed result until pop.
module histogram_auto_exposure (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [23:0] i_bucket_count,
    input  wire logic        i_is_last,
    input  wire logic        i_hist_valid,
    input  wire logic [19:0] i_frame_exposure,
    input  wire logic [15:0] i_frame_gain,
    input  wire logic [19:0] i_prior_exposure,
    input  wire logic [15:0] i_prior_gain,
    output logic             empty,
    input  wire logic        pop,
    output logic [19:0]      o_new_exposure,
    output logic [15:0]      o_new_gain,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);
    hae_pkg::t_cfg r_cfg;
    hae_pkg::t_job w_job;
    logic w_we, w_job_rdy, w_take, w_busy;
    logic [hae_pkg::BIDX_W-1:0] w_waddr, w_raddr;
    logic [23:0] w_wdata, w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pct <= 11'd922;
            r_cfg.tgt <= 11'd410;
            r_cfg.maxg <= 16'd8192;
            r_cfg.knee <= 20'd40000;
            r_cfg.maxe <= 20'd125000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hae_pkg::REG_PCT:  r_cfg.pct <= i_cfg_data[10:0];
                hae_pkg::REG_TGT:  r_cfg.tgt <= i_cfg_data[10:0];
                hae_pkg::REG_MAXG: r_cfg.maxg <= i_cfg_data[15:0];
                hae_pkg::REG_KNEE: r_cfg.knee <= i_cfg_data;
                hae_pkg::REG_MAXE: r_cfg.maxe <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hae_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_bucket_count(i_bucket_count), .i_is_last(i_is_last),
        .i_hist_valid(i_hist_valid), .i_frame_exposure(i_frame_exposure),
        .i_frame_gain(i_frame_gain), .i_prior_exposure(i_prior_exposure),
        .i_prior_gain(i_prior_gain), .o_we(w_we), .o_waddr(w_waddr),
        .o_wdata(w_wdata), .o_job_rdy(w_job_rdy), .o_job(w_job),
        .i_job_take(w_take), .i_bank_busy(w_busy)
    );

    hae_ram #(.WIDTH(24), .DEPTH(hae_pkg::BUCKETS)) u_bins (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    hae_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_job_rdy(w_job_rdy),
        .i_job(w_job), .o_job_take(w_take), .o_busy(w_busy), .o_raddr(w_raddr),
        .i_rdata(w_rdata), .o_empty(empty), .i_pop(pop),
        .o_new_exposure(o_new_exposure), .o_new_gain(o_new_gain)
    );
endmodule
`default_nettype wire

@@ rtl/core/hae_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hae_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/hae_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Zero divisor yields all ones.
module hae_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo
);
    logic [63:0] r_quo, r_rem, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_quo[63]};
    assign o_quo = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'd64;
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= 64'(w_trial - {1'b0, r_den});
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/hae_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_auto_exposure_defines.svh"
// Stores buckets, keeps the running total, queues a job at each last bucket.
module hae_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic [23:0]                i_bucket_count,
    input  wire logic                       i_is_last,
    input  wire logic                       i_hist_valid,
    input  wire logic [19:0]                i_frame_exposure,
    input  wire logic [15:0]                i_frame_gain,
    input  wire logic [19:0]                i_prior_exposure,
    input  wire logic [15:0]                i_prior_gain,
    output logic                            o_we,
    output logic [hae_pkg::BIDX_W-1:0]      o_waddr,
    output logic [23:0]                     o_wdata,
    output logic                            o_job_rdy,
    output hae_pkg::t_job                   o_job,
    input  wire logic                       i_job_take,
    input  wire logic                       i_bank_busy
);
    logic [hae_pkg::BCNT_W-1:0] r_idx;
    logic [hae_pkg::TOT_W-1:0]  r_tot;
    hae_pkg::t_job              r_q [hae_pkg::QDEPTH];
    logic [1:0]                 r_cnt;
    logic                       w_acc, w_store;
    logic [hae_pkg::TOT_W:0]    w_sum;
    logic [hae_pkg::TOT_W-1:0]  w_tot;
    hae_pkg::t_job              w_job;

    // The back part scans the bins; hold buckets while a job waits or it is busy.
    assign o_full = (r_cnt != 2'd0) || i_bank_busy;
    assign w_acc = i_push && !o_full;
    assign w_store = w_acc && (r_idx < hae_pkg::BCNT_W'(hae_pkg::BUCKETS));
    assign w_sum = {1'b0, r_tot} + (hae_pkg::TOT_W+1)'(i_bucket_count);
    assign w_tot = !w_store ? r_tot
        : (w_sum > {1'b0, hae_pkg::TOTAL_MAX}) ? hae_pkg::TOTAL_MAX
        : w_sum[hae_pkg::TOT_W-1:0];

    assign o_we = w_store;
    assign o_waddr = r_idx[hae_pkg::BIDX_W-1:0];
    assign o_wdata = i_bucket_count;
    assign o_job_rdy = r_cnt != 2'd0;
    assign o_job = r_q[0];

    always_comb begin
        w_job.valid = i_hist_valid;
        w_job.n = w_store ? r_idx + 1'b1 : r_idx;
        w_job.total = w_tot;
        w_job.fe = i_frame_exposure;
        w_job.fg = i_frame_gain;
        w_job.pe = i_prior_exposure;
        w_job.pg = i_prior_gain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_tot <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc && i_is_last) begin
                r_idx <= '0;
                r_tot <= '0;
            end else begin
                if (w_store) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_tot <= w_tot;
            end
            if (i_job_take && r_cnt != 2'd0) begin
                r_q[0] <= r_q[1];
            end
            if (w_acc && i_is_last) begin
                if (i_job_take && r_cnt != 2'd0) begin
                    r_q[1'(r_cnt - 2'd1)] <= w_job;
                end else begin
                    r_q[r_cnt[0]] <= w_job;
                end
            end
            r_cnt <= r_cnt + {1'b0, w_acc && i_is_last}
                - {1'b0, i_job_take && r_cnt != 2'd0};
        end
    end

    `HAE_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1,
        r_idx <= hae_pkg::BCNT_W'(hae_pkg::BUCKETS), "bucket index overran")
    `HAE_ASSERT_IMP(a_no_store_full, i_clk, i_rst_n, o_full, !o_we,
        "bin write while stalled")
    `HAE_ASSERT_NEXT(a_clear_last, i_clk, i_rst_n, w_acc && i_is_last,
        r_idx == '0 && r_tot == '0, "frame state not cleared")
endmodule
`default_nettype wire

@@ rtl/core/hae_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "histogram_auto_exposure_defines.svh"
// Sequencer: scan bins, compute brightness, blend, split into exposure and gain.
module hae_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire hae_pkg::t_cfg          i_cfg,
    input  wire logic                   i_job_rdy,
    input  wire hae_pkg::t_job          i_job,
    output logic                        o_job_take,
    output logic                        o_busy,
    output logic [hae_pkg::BIDX_W-1:0]  o_raddr,
    input  wire logic [23:0]            i_rdata,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output logic [19:0]                 o_new_exposure,
    output logic [15:0]                 o_new_gain
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SCAN  = 14'b00000000000010,
        S_BMUL  = 14'b00000000000100,
        S_DMUL1 = 14'b00000000001000,
        S_DMUL2 = 14'b00000000010000,
        S_DDIV  = 14'b00000000100000,
        S_OMUL  = 14'b00000001000000,
        S_RDIV  = 14'b00000010000000,
        S_BLD1  = 14'b00000100000000,
        S_BLD2  = 14'b10000000000000,
        S_KDIV  = 14'b00001000000000,
        S_GDIV  = 14'b00010000000000,
        S_FIN   = 14'b00100000000000,
        S_OUT   = 14'b01000000000000
    } t_state;

    t_state r_state;
    hae_pkg::t_job r_job;
    logic [hae_pkg::BCNT_W-1:0] r_i;
    logic        r_rv;
    logic [hae_pkg::BIDX_W-1:0] r_ridx;
    logic [31:0] r_acc;
    logic [41:0] r_thr;
    logic        r_found;
    logic [hae_pkg::BIDX_W-1:0] r_fidx;
    logic [63:0] r_d, r_o, r_f, r_t, r_expo;
    logic [16:0] r_gain;
    logic [10:0] r_r;
    logic        r_kpath;
    logic        r_dstart;
    logic [63:0] r_dnum, r_dden;
    logic        w_ddone;
    logic [63:0] w_dquo;
    logic [31:0] w_acc2;
    logic [63:0] w_hi, w_lo;
    logic [11:0] w_s;

    hae_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(w_ddone), .o_quo(w_dquo)
    );

    assign o_raddr = r_ridx;
    assign o_busy = r_state != S_IDLE;
    assign o_job_take = r_state == S_IDLE && i_job_rdy;
    assign w_acc2 = r_acc + 32'(i_rdata);
    assign w_hi = (r_d > r_o) ? r_d : r_o;
    assign w_lo = (r_d > r_o) ? r_o : r_d;
    assign w_s = 12'd2048 - {1'b0, r_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_empty <= 1'b1;
            r_dstart <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (!o_empty && i_pop) begin
                o_empty <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_rdy) begin
                        r_job <= i_job;
                        r_i <= '0;
                        r_ridx <= '0;
                        r_rv <= 1'b0;
                        r_acc <= '0;
                        r_found <= 1'b0;
                        r_thr <= 42'(i_job.total) * 42'(i_cfg.pct);
                        if (!i_job.valid) begin
                            r_expo <= 64'(i_job.pe);
                            r_gain <= 17'(i_job.pg);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Read a bin per cycle; data lands the cycle after its address.
                    if (r_rv) begin
                        r_acc <= w_acc2;
                        if ({w_acc2, 10'd0} > r_thr) begin
                            r_found <= 1'b1;
                            r_fidx <= r_ridx - 1'b1;
                            r_state <= S_BMUL;
                        end
                    end
                    if (r_state == S_SCAN && !(r_rv && {w_acc2, 10'd0} > r_thr)) begin
                        if (r_i >= r_job.n) begin
                            r_state <= S_BMUL;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_ridx <= hae_pkg::BIDX_W'(r_i + 1'b1);
                            r_rv <= 1'b1;
                        end
                    end
                end
                S_BMUL: begin
                    r_d <= 64'(r_job.fe) * 64'(r_job.fg);
                    r_state <= S_DMUL1;
                end
                S_DMUL1: begin
                    if (!r_found || 32'(r_fidx) + 32'd1 >= 32'(hae_pkg::BUCKETS)) begin
                        r_d <= r_d >> 1;
                        r_state <= S_OMUL;
                    end else begin
                        r_t <= 64'(r_d[35:0] * 47'(i_cfg.tgt));
                        r_state <= S_DMUL2;
                    end
                end
                S_DMUL2: begin
                    r_dnum <= r_t * 64'(hae_pkg::BUCKETS);
                    r_dden <= 64'(1024) * (64'(r_fidx) + 64'd1);
                    r_dstart <= 1'b1;
                    r_state <= S_DDIV;
                end
                S_DDIV: begin
                    if (w_ddone) begin
                        r_d <= w_dquo;
                        r_state <= S_OMUL;
                    end
                end
                S_OMUL: begin
                    r_o <= 64'(r_job.pe) * 64'(r_job.pg);
                    r_state <= S_RDIV;
                    r_r <= hae_pkg::RATIO_CAP;
                    r_kpath <= 1'b0;
                end
                S_RDIV: begin
                    if (!r_kpath) begin
                        r_kpath <= 1'b1;
                        if (w_lo != '0) begin
                            r_dnum <= w_hi << 10;
                            r_dden <= w_lo;
                            r_dstart <= 1'b1;
                        end else begin
                            r_state <= S_BLD1;
                        end
                    end else if (w_ddone) begin
                        r_r <= (w_dquo > 64'(hae_pkg::RATIO_CAP)) ? hae_pkg::RATIO_CAP
                            : w_dquo[10:0];
                        r_state <= S_BLD1;
                    end
                end
                S_BLD1: begin
                    r_t <= 64'(r_d[47:0] * 60'(12'd1024 - w_s));
                    r_f <= 64'(r_o[47:0] * 60'(w_s));
                    r_state <= S_BLD2;
                end
                S_BLD2: begin
                    r_f <= (r_t + r_f) >> 10;
                    r_state <= S_KDIV;
                    r_kpath <= 1'b0;
                end
                S_KDIV: begin
                    if (!r_kpath) begin
                        r_kpath <= 1'b1;
                        if (r_f > {36'd0, i_cfg.knee, 8'd0}) begin
                            r_expo <= 64'(i_cfg.knee);
                            if (i_cfg.knee == '0) begin
                                r_gain <= 17'h1FFFF;
                                r_state <= S_GDIV;
                                r_kpath <= 1'b0;
                            end else begin
                                r_dnum <= r_f;
                                r_dden <= 64'(i_cfg.knee);
                                r_dstart <= 1'b1;
                            end
                        end else begin
                            r_expo <= r_f >> 8;
                            r_gain <= 17'd256;
                            r_state <= S_GDIV;
                            r_kpath <= 1'b0;
                        end
                    end else if (w_ddone) begin
                        r_gain <= (w_dquo > 64'h1FFFF) ? 17'h1FFFF : w_dquo[16:0];
                        r_state <= S_GDIV;
                        r_kpath <= 1'b0;
                    end
                end
                S_GDIV: begin
                    if (!r_kpath) begin
                        r_kpath <= 1'b1;
                        if (r_gain > 17'(i_cfg.maxg)) begin
                            r_gain <= 17'(i_cfg.maxg);
                            if (i_cfg.maxg == '0) begin
                                r_expo <= 64'hFFFFF;
                                r_state <= S_FIN;
                            end else begin
                                r_dnum <= r_f;
                                r_dden <= 64'(i_cfg.maxg);
                                r_dstart <= 1'b1;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (w_ddone) begin
                        r_expo <= w_dquo;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_expo > 64'(i_cfg.maxe)) begin
                        r_expo <= 64'(i_cfg.maxe);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_empty || i_pop) begin
                        o_new_exposure <= r_expo[19:0];
                        o_new_gain <= r_gain[15:0];
                        o_empty <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HAE_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_job_take, r_state == S_IDLE,
        "job taken while busy")
    `HAE_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n,
        r_state == S_OUT && o_empty, !o_empty, "result not presented")
    `HAE_ASSERT_IMP(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state),
        "state not one-hot")
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    typedef struct {
        logic [19:0] expo;
        logic [15:0] gain;
    } t_setting;

    typedef struct {
        logic [23:0] cnt;
        logic        last;
        logic        valid;
        logic [19:0] fe;
        logic [15:0] fg;
        logic [19:0] pe;
        logic [15:0] pg;
        logic        typed;
        logic [19:0] t_expo;
        logic [15:0] t_gain;
    } t_row;

    localparam int DIR_ROWS = 14;
    localparam int SETTLE_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [23:0] i_bucket_count = '0;
    logic        i_is_last = 1'b0;
    logic        i_hist_valid = 1'b0;
    logic [19:0] i_frame_exposure = '0;
    logic [15:0] i_frame_gain = 16'd256;
    logic [19:0] i_prior_exposure = '0;
    logic [15:0] i_prior_gain = 16'd256;
    logic        empty;
    logic        pop = 1'b0;
    logic [19:0] o_new_exposure;
    logic [15:0] o_new_gain;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;

    // predictor state
    logic [10:0] pct_q = 11'd922;
    logic [10:0] tgt_q = 11'd410;
    logic [15:0] maxg_q = 16'd8192;
    logic [19:0] knee_q = 20'd40000;
    logic [19:0] maxe_q = 20'd125000;
    logic [23:0] bins_q [hae_pkg::BUCKETS];
    int unsigned nbins_q = 0;
    logic [hae_pkg::TOT_W-1:0] sum_q = '0;

    t_setting pending_q[$];
    int       mismatches = 0;
    bit       calm = 1'b0;
    int       stall_left = 0;

    histogram_auto_exposure u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_bucket_count   (i_bucket_count),
        .i_is_last        (i_is_last),
        .i_hist_valid     (i_hist_valid),
        .i_frame_exposure (i_frame_exposure),
        .i_frame_gain     (i_frame_gain),
        .i_prior_exposure (i_prior_exposure),
        .i_prior_gain     (i_prior_gain),
        .empty            (empty),
        .pop              (pop),
        .o_new_exposure   (o_new_exposure),
        .o_new_gain       (o_new_gain),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("histogram_auto_exposure: mismatch");
        $finish;
    end

    // Store one bucket; on the last one compute the next exposure setting.
    function automatic bit meter_frame(input t_row r, output t_setting res);
        logic [63:0] acc, tot, d, o, f, hi, lo, ratio, s, expo, gain;
        int unsigned n, idx;
        bit found;
        acc = 0;
        idx = 0;
        found = 1'b0;
        if (nbins_q < hae_pkg::BUCKETS) begin
            bins_q[nbins_q] = r.cnt;
            nbins_q++;
            tot = 64'(sum_q) + 64'(r.cnt);
            sum_q = (tot > 64'(hae_pkg::TOTAL_MAX)) ? hae_pkg::TOTAL_MAX
                                                    : tot[hae_pkg::TOT_W-1:0];
        end
        if (!r.last) return 1'b0;
        n = nbins_q;
        tot = 64'(sum_q);
        nbins_q = 0;
        sum_q = '0;
        if (!r.valid) begin
            res.expo = r.pe;
            res.gain = r.pg;
            return 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            acc += 64'(bins_q[i]);
            if (!found && acc * 1024 > tot * 64'(pct_q)) begin
                found = 1'b1;
                idx = i;
            end
        end
        d = 64'(r.fe) * 64'(r.fg);
        if (!found || idx + 1 >= hae_pkg::BUCKETS)
            d = d >> 1;
        else
            d = (d * 64'(tgt_q) * hae_pkg::BUCKETS) / (64'd1024 * 64'(idx + 1));
        o = 64'(r.pe) * 64'(r.pg);
        hi = (d > o) ? d : o;
        lo = (d > o) ? o : d;
        ratio = 64'(hae_pkg::RATIO_CAP);
        if (lo != 0) begin
            ratio = (hi * 1024) / lo;
            if (ratio > 64'(hae_pkg::RATIO_CAP)) ratio = 64'(hae_pkg::RATIO_CAP);
        end
        s = 2048 - ratio;
        f = ((1024 - s) * d + s * o) >> 10;
        if (f > 64'(knee_q) * 256) begin
            expo = 64'(knee_q);
            gain = (knee_q != 0) ? f / 64'(knee_q) : '1;
        end else begin
            expo = f >> 8;
            gain = 256;
        end
        if (gain > 64'(maxg_q)) begin
            expo = (maxg_q != 0) ? f / 64'(maxg_q) : 64'hFFFFF;
            gain = 64'(maxg_q);
        end
        if (expo > 64'(maxe_q)) expo = 64'(maxe_q);
        res.expo = expo[19:0];
        res.gain = gain[15:0];
        return 1'b1;
    endfunction

    // Result side: check each transfer, then pick the next stall.
    always @(posedge i_clk) begin
        t_setting want;
        if (i_rst_n && pop && !empty) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: exposure %0d gain %0d",
                             o_new_exposure, o_new_gain);
            end else begin
                want = pending_q.pop_front();
                if (want.expo !== o_new_exposure || want.gain !== o_new_gain) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: expected exposure %0d gain %0d, got %0d %0d",
                                 want.expo, want.gain, o_new_exposure, o_new_gain);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
        end
    end

    task automatic send_bucket(input t_row r);
        t_setting res;
        i_bucket_count   <= r.cnt;
        i_is_last        <= r.last;
        i_hist_valid     <= r.valid;
        i_frame_exposure <= r.fe;
        i_frame_gain     <= r.fg;
        i_prior_exposure <= r.pe;
        i_prior_gain     <= r.pg;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (meter_frame(r, res)) begin
            if (r.typed) begin
                res.expo = r.t_expo;
                res.gain = r.t_gain;
            end
            pending_q.push_back(res);
        end
        // hold push for back-to-back transfers unless a gap is chosen
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 2))
                @(posedge i_clk);
        end
    endtask

    task automatic drain;
        push <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Valid stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            hae_pkg::REG_PCT:  pct_q  = val[10:0];
            hae_pkg::REG_TGT:  tgt_q  = val[10:0];
            hae_pkg::REG_MAXG: maxg_q = val[15:0];
            hae_pkg::REG_KNEE: knee_q = val;
            hae_pkg::REG_MAXE: maxe_q = val;
            default: ;
        endcase
    endtask

    function automatic t_row random_bucket(input int mode, input bit last);
        t_row r;
        case (mode)
            0: r.cnt = $urandom_range(0, 4095);
            1: r.cnt = 24'hFFFFFF;
            2: r.cnt = '0;
            default: r.cnt = $urandom;
        endcase
        r.last  = last;
        r.valid = last ? ($urandom_range(0, 6) != 0) : $urandom_range(0, 1);
        r.fe    = ($urandom_range(0, 7) == 0) ? 20'd1000000 : $urandom_range(0, 1000000);
        r.fg    = ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(256, 65535);
        r.pe    = ($urandom_range(0, 7) == 0) ? 20'd0 : $urandom_range(0, 1000000);
        r.pg    = ($urandom_range(0, 7) == 0) ? 16'd256 : $urandom_range(256, 65535);
        r.typed = 1'b0;
        r.t_expo = '0;
        r.t_gain = '0;
        return r;
    endfunction

    initial begin
        t_row dir_rows [DIR_ROWS];
        logic [19:0] phase_cfg [5][5];
        int sent, len, mode, quota;

        dir_rows[0]  = '{24'hFFFFFF, 1, 0, 20'd0, 16'd256, 20'd1000000, 16'hFFFF,
                         1, 20'd1000000, 16'hFFFF};
        dir_rows[1]  = '{24'd0, 1, 0, 20'd1000000, 16'hFFFF, 20'd0, 16'd256,
                         1, 20'd0, 16'd256};
        dir_rows[2]  = '{24'd0, 1, 1, 20'd0, 16'd256, 20'd0, 16'd256,
                         1, 20'd0, 16'd256};
        dir_rows[3]  = '{24'd0, 1, 1, 20'd1000000, 16'hFFFF, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[4]  = '{24'hFFFFFF, 1, 1, 20'd1000000, 16'hFFFF, 20'd1000000, 16'hFFFF,
                         0, 0, 0};
        dir_rows[5]  = '{24'd1, 0, 1, 20'd0, 16'd256, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[6]  = '{24'd2, 0, 0, 20'd0, 16'd256, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[7]  = '{24'd3, 0, 1, 20'd0, 16'd256, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[8]  = '{24'd4, 0, 1, 20'd0, 16'd256, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[9]  = '{24'd50, 1, 1, 20'd20000, 16'd512, 20'd30000, 16'd300, 0, 0, 0};
        dir_rows[10] = '{24'hFFFFFF, 0, 1, 20'd0, 16'd256, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[11] = '{24'hFFFFFF, 0, 1, 20'd0, 16'd256, 20'd0, 16'd256, 0, 0, 0};
        dir_rows[12] = '{24'd0, 1, 1, 20'd100, 16'd256, 20'd500000, 16'd8192, 0, 0, 0};
        dir_rows[13] = '{24'd7, 1, 1, 20'd1, 16'd256, 20'd1, 16'd256, 0, 0, 0};

        phase_cfg[0] = '{20'd0, 20'd1, 20'd0, 20'd0, 20'd1};
        phase_cfg[1] = '{20'd1024, 20'd1024, 20'd65535, 20'd1000000, 20'd1000000};
        phase_cfg[2] = '{20'd2047, 20'd2047, 20'd100, 20'hFFFFF, 20'hFFFFF};
        phase_cfg[3] = '{20'd512, 20'd600, 20'd256, 20'd1, 20'd500000};
        phase_cfg[4] = '{$urandom_range(0, 1024), $urandom_range(1, 1024),
                         $urandom_range(256, 65535), $urandom_range(1, 1000000),
                         $urandom_range(1, 1000000)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) send_bucket(dir_rows[i]);

        // default settings first, then the extremes, then a random setting
        for (int ph = 0; ph <= 5; ph++) begin
            if (ph > 0) begin
                drain();
                for (int k = 0; k < 5; k++) write_reg(k[2:0], phase_cfg[ph-1][k]);
                i_cfg_valid <= 1'b0;
            end
            quota = 320;
            sent = 0;
            while (sent < quota) begin
                calm = ($urandom_range(0, 3) == 0);
                mode = $urandom_range(0, 9);
                if (mode == 0)
                    len = $urandom_range(65, 72);
                else if (mode == 1)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(1, 64);
                // a frame of full buckets takes the total near saturation
                mode = ($urandom_range(0, 9) == 0) ? 1 : -1;
                if (mode == 1) len = hae_pkg::BUCKETS;
                for (int b = 0; b < len; b++) begin
                    int m;
                    m = (mode == 1) ? 1 : ($urandom_range(0, 19) < 14 ? 0 :
                                           $urandom_range(1, 3));
                    send_bucket(random_bucket(m, b == len - 1));
                end
                sent += len;
            end
        end
        calm = 1'b0;
        drain();
        if (pending_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("histogram_auto_exposure: match");
        end else begin
            $display("histogram_auto_exposure: mismatch");
        end
        $finish;
    end
endmodule
